// File: design/nti_pkg.sv
// Shared types and constants for the Neville table interpolator.
// No dependencies; used by nti_div and neville_table_interpolator_core.
package nti_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_ORDER_DEF  = 7;

    // Width of the point-count style counters (order is 3 bits, so k <= 8)
    localparam int KW = 4;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_BELOW   = 3'd1;
    localparam logic [2:0] STAT_ABOVE   = 3'd2;
    localparam logic [2:0] STAT_ZERODIV = 3'd3;
    localparam logic [2:0] STAT_ORDER   = 3'd4;
    localparam logic [2:0] STAT_SAT     = 3'd5;

    // Configuration register indexes and reset values
    localparam logic       CFG_NUM_POINTS = 1'b0;
    localparam logic       CFG_ORDER      = 1'b1;
    localparam logic [6:0] NUM_POINTS_RST = 7'd64;
    localparam logic [2:0] ORDER_RST      = 3'd1;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         point_index;
        logic signed [31:0] abscissa;
        logic signed [31:0] ordinate;
        logic signed [31:0] query_x;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic [5:0]         bin_found;
        logic [2:0]         result_status;
    } t_out_item;

    // Divider request and answer
    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic        neg;
        logic [63:0] mag;
    } t_div_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_BIS_RD,
        S_BIS_CMP,
        S_ORDER,
        S_NB_LO,
        S_NB_HI,
        S_CLAMP,
        S_FILL_RD,
        S_FILL_WR,
        S_NV_RDI,
        S_NV_RDM,
        S_NV_A,
        S_NV_B,
        S_NV_D,
        S_NV_M1,
        S_NV_M2,
        S_NV_SUM,
        S_NV_DIVGO,
        S_NV_DIV,
        S_NV_DROP,
        S_FINISH,
        S_DONE
    } t_state;

endpackage

// File: design/nti_div.sv
// Iterative signed 64-by-32 divider, one quotient bit per cycle, truncating.
// Depends on nti_pkg for the request and answer structs.
module nti_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nti_pkg::t_div_req i_req,
    output nti_pkg::t_div_res o_res
);

    logic        r_busy;
    logic        r_done;
    logic        r_neg;
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_dv;
    logic [5:0]  r_cnt;

    logic [32:0] rem_sh;
    logic        ge;

    // Restoring step: shift in the next dividend bit and try the subtract
    always_comb begin
        rem_sh = {r_rem, r_q[63]};
        ge     = (rem_sh >= {1'b0, r_dv});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitudes at start, then one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.num[63] ^ i_req.den[31];
            r_q   <= i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num);
            r_dv  <= i_req.den[31] ? 32'(-i_req.den) : 32'(i_req.den);
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], ge};
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_dv}) : rem_sh[31:0];
        end
    end

    assign o_res = '{done: r_done, neg: r_neg, mag: r_q};

endmodule

// File: design/neville_table_interpolator_core.sv
// Neville table interpolator: point table, bisection and Neville recurrence
// sequenced over one subtractor, one multiplier and one divider (nti_div).
// A query runs k(k-1)/2 Neville updates, each waiting on the bit-serial division.
// Throughput: one item at a time; the next item is taken when this one ends.
// Reset (synchronous, active low): num_points 64, order 1; table undefined.
module neville_table_interpolator_core #(
    parameter int MAX_POINTS = nti_pkg::MAX_POINTS_DEF,
    parameter int MAX_ORDER  = nti_pkg::MAX_ORDER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nti_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nti_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW = AW + 2;
    localparam int SL = MAX_ORDER + 2;
    localparam int SW = $clog2(SL);
    localparam int KW = nti_pkg::KW;

    nti_pkg::t_state r_state, n_state;

    logic [6:0] r_np;
    logic [2:0] r_ord;

    logic signed [31:0] r_x, n_x;
    logic signed [IW-1:0] r_n, n_n, r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic signed [IW-1:0] r_bin, n_bin, r_org, n_org;
    logic [KW-1:0] r_i, n_i, r_c, n_c, r_m, n_m;
    logic signed [32:0] r_e1, n_e1;
    logic signed [31:0] r_di, n_di, r_dm, n_dm, r_a, n_a, r_b, n_b, r_den, n_den;
    logic signed [63:0] r_pa, n_pa, r_pb, n_pb, r_num, n_num;
    logic r_sat, n_sat;
    nti_pkg::t_out_item r_res, n_res;
    logic signed [31:0] r_s [SL];
    logic signed [31:0] n_s [SL];

    logic signed [31:0] r_dmem [MAX_POINTS];
    logic signed [31:0] r_omem [MAX_POINTS];
    logic signed [31:0] r_dq, r_oq;
    logic [AW-1:0] mem_raddr;

    logic r_out_valid;
    nti_pkg::t_out_item r_out;

    logic in_acc, out_free;
    logic [KW-1:0] k;
    logic signed [IW-1:0] n_clamp;

    // Shared subtractor with saturation
    logic signed [31:0] sub_l, sub_r, sub_sat;
    logic signed [32:0] sub_d;
    logic sub_ovf;
    // Shared multiplier
    logic signed [31:0] mul_l, mul_r;
    logic signed [63:0] mul_p;

    nti_pkg::t_div_req div_req;
    nti_pkg::t_div_res div_res;
    logic signed [31:0] q_sat;
    logic q_ovf;

    assign o_in_stall  = (r_state != nti_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign k           = KW'({1'b0, r_ord}) + KW'(1);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Point count held to 1..MAX_POINTS
    always_comb begin
        if (r_np == 7'd0) begin
            n_clamp = IW'(1);
        end else if (int'(r_np) > MAX_POINTS) begin
            n_clamp = IW'(MAX_POINTS);
        end else begin
            n_clamp = IW'(r_np);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np  <= nti_pkg::NUM_POINTS_RST;
            r_ord <= nti_pkg::ORDER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nti_pkg::CFG_NUM_POINTS: r_np  <= i_cfg_data;
                nti_pkg::CFG_ORDER:      r_ord <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Point table: written on a load transfer, read address from the sequencer
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.opcode == nti_pkg::OP_LOAD
                && int'(i_in_item.point_index) < MAX_POINTS) begin
            r_dmem[AW'(i_in_item.point_index)] <= i_in_item.abscissa;
            r_omem[AW'(i_in_item.point_index)] <= i_in_item.ordinate;
        end
        r_dq <= r_dmem[mem_raddr];
        r_oq <= r_omem[mem_raddr];
    end

    // Read address per state
    always_comb begin
        case (r_state)
            nti_pkg::S_CHK_FIRST: mem_raddr = AW'(r_n - IW'(1));
            nti_pkg::S_BIS_RD:    mem_raddr = AW'(r_mid);
            nti_pkg::S_ORDER:     mem_raddr = AW'(r_bin);
            nti_pkg::S_NB_LO:     mem_raddr = AW'(r_bin + IW'(1));
            nti_pkg::S_FILL_RD:   mem_raddr = AW'(r_org + IW'(r_i));
            nti_pkg::S_NV_RDI:    mem_raddr = AW'(r_org + IW'(r_i));
            nti_pkg::S_NV_RDM:    mem_raddr = AW'(r_org + IW'(r_i) + IW'(r_m));
            default:              mem_raddr = '0;
        endcase
    end

    // Shared subtract and multiply operands
    always_comb begin
        case (r_state)
            nti_pkg::S_NB_HI: begin sub_l = r_dq; sub_r = r_x;  end
            nti_pkg::S_NV_B:  begin sub_l = r_di; sub_r = r_x;  end
            nti_pkg::S_NV_D:  begin sub_l = r_di; sub_r = r_dm; end
            default:          begin sub_l = r_x;  sub_r = r_dq; end
        endcase
        sub_d   = 33'(sub_l) - 33'(sub_r);
        sub_ovf = (sub_d[32] != sub_d[31]);
        if (!sub_ovf) begin
            sub_sat = sub_d[31:0];
        end else if (sub_d[32]) begin
            sub_sat = 32'sh8000_0000;
        end else begin
            sub_sat = 32'sh7FFF_FFFF;
        end
        if (r_state == nti_pkg::S_NV_M2) begin
            mul_l = r_b; mul_r = r_s[1];
        end else begin
            mul_l = r_a; mul_r = r_s[0];
        end
        mul_p = 64'(mul_l) * 64'(mul_r);
    end

    // Divider and quotient saturation
    assign div_req = '{start: (r_state == nti_pkg::S_NV_DIVGO), num: r_num, den: r_den};

    nti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    always_comb begin
        q_ovf = 1'b0;
        if (div_res.neg) begin
            if (div_res.mag > 64'h8000_0000) begin
                q_sat = 32'sh8000_0000;
                q_ovf = 1'b1;
            end else begin
                q_sat = 32'(-div_res.mag[31:0]);
            end
        end else if (div_res.mag > 64'h7FFF_FFFF) begin
            q_sat = 32'sh7FFF_FFFF;
            q_ovf = 1'b1;
        end else begin
            q_sat = div_res.mag[31:0];
        end
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nti_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_item.opcode == nti_pkg::OP_LOAD) ?
                              nti_pkg::S_DONE : nti_pkg::S_RD_FIRST;
                end
            end
            nti_pkg::S_RD_FIRST:  n_state = nti_pkg::S_CHK_FIRST;
            nti_pkg::S_CHK_FIRST: n_state = (r_x < r_dq) ? nti_pkg::S_DONE
                                                         : nti_pkg::S_CHK_LAST;
            nti_pkg::S_CHK_LAST:  n_state = (r_x > r_dq) ? nti_pkg::S_DONE
                                                         : nti_pkg::S_BIS_RD;
            nti_pkg::S_BIS_RD:    n_state = (r_lo == r_hi) ? nti_pkg::S_ORDER
                                                           : nti_pkg::S_BIS_CMP;
            nti_pkg::S_BIS_CMP:   n_state = (r_x == r_dq) ? nti_pkg::S_ORDER
                                                          : nti_pkg::S_BIS_RD;
            nti_pkg::S_ORDER: begin
                if (int'(r_ord) > MAX_ORDER || int'(k) > int'(r_n)) begin
                    n_state = nti_pkg::S_DONE;
                end else if (k[0]) begin
                    n_state = nti_pkg::S_NB_LO;
                end else begin
                    n_state = nti_pkg::S_CLAMP;
                end
            end
            nti_pkg::S_NB_LO: n_state = (r_bin + IW'(1) < r_n) ? nti_pkg::S_NB_HI
                                                               : nti_pkg::S_CLAMP;
            nti_pkg::S_NB_HI: n_state = nti_pkg::S_CLAMP;
            nti_pkg::S_CLAMP: n_state = nti_pkg::S_FILL_RD;
            nti_pkg::S_FILL_RD: n_state = nti_pkg::S_FILL_WR;
            nti_pkg::S_FILL_WR: begin
                if (r_i + KW'(1) != k) begin
                    n_state = nti_pkg::S_FILL_RD;
                end else if (k == KW'(1)) begin
                    n_state = nti_pkg::S_FINISH;
                end else begin
                    n_state = nti_pkg::S_NV_RDI;
                end
            end
            nti_pkg::S_NV_RDI: n_state = nti_pkg::S_NV_RDM;
            nti_pkg::S_NV_RDM: n_state = nti_pkg::S_NV_A;
            nti_pkg::S_NV_A:   n_state = nti_pkg::S_NV_B;
            nti_pkg::S_NV_B:   n_state = nti_pkg::S_NV_D;
            nti_pkg::S_NV_D:   n_state = (sub_sat == 32'sd0) ? nti_pkg::S_DONE
                                                            : nti_pkg::S_NV_M1;
            nti_pkg::S_NV_M1:    n_state = nti_pkg::S_NV_M2;
            nti_pkg::S_NV_M2:    n_state = nti_pkg::S_NV_SUM;
            nti_pkg::S_NV_SUM:   n_state = nti_pkg::S_NV_DIVGO;
            nti_pkg::S_NV_DIVGO: n_state = nti_pkg::S_NV_DIV;
            nti_pkg::S_NV_DIV: begin
                if (div_res.done) begin
                    n_state = (r_i + KW'(1) == r_c - KW'(1)) ? nti_pkg::S_NV_DROP
                                                             : nti_pkg::S_NV_RDI;
                end
            end
            nti_pkg::S_NV_DROP: n_state = (r_c == KW'(2)) ? nti_pkg::S_FINISH
                                                          : nti_pkg::S_NV_RDI;
            nti_pkg::S_FINISH: n_state = nti_pkg::S_DONE;
            nti_pkg::S_DONE:   n_state = out_free ? nti_pkg::S_IDLE : nti_pkg::S_DONE;
            default:           n_state = nti_pkg::S_IDLE;
        endcase
    end

    // Sequencer: datapath updates per state
    always_comb begin
        logic signed [IW-1:0] hi_nx, lo_nx, org_b;
        n_x = r_x; n_n = r_n; n_lo = r_lo; n_hi = r_hi; n_mid = r_mid;
        n_bin = r_bin; n_org = r_org; n_i = r_i; n_c = r_c; n_m = r_m;
        n_e1 = r_e1; n_di = r_di; n_dm = r_dm; n_a = r_a; n_b = r_b;
        n_den = r_den; n_pa = r_pa; n_pb = r_pb; n_num = r_num;
        n_sat = r_sat; n_res = r_res; n_s = r_s;
        hi_nx = r_hi; lo_nx = r_lo;
        org_b = r_bin - IW'(k >> 1);
        case (r_state)
            nti_pkg::S_IDLE: begin
                n_x   = i_in_item.query_x;
                n_n   = n_clamp;
                n_sat = 1'b0;
                n_res = '0;
            end
            nti_pkg::S_CHK_FIRST: begin
                // below the domain: first ordinate
                n_res.interp_value  = r_oq;
                n_res.bin_found     = '0;
                n_res.result_status = nti_pkg::STAT_BELOW;
            end
            nti_pkg::S_CHK_LAST: begin
                // above the domain: last ordinate
                n_res.interp_value  = r_oq;
                n_res.bin_found     = 6'(r_n - IW'(1));
                n_res.result_status = nti_pkg::STAT_ABOVE;
                n_lo  = '0;
                n_hi  = (r_n >= IW'(2)) ? r_n - IW'(2) : '0;
                n_mid = (n_hi + IW'(1)) >>> 1;
            end
            nti_pkg::S_BIS_RD: begin
                n_bin = r_lo;
            end
            nti_pkg::S_BIS_CMP: begin
                if (r_x == r_dq) begin
                    n_bin = r_mid;
                end else begin
                    if (r_x < r_dq) begin
                        hi_nx = r_mid - IW'(1);
                    end else begin
                        lo_nx = r_mid;
                    end
                    n_hi  = hi_nx;
                    n_lo  = lo_nx;
                    n_mid = (hi_nx + lo_nx + IW'(1)) >>> 1;
                end
            end
            nti_pkg::S_ORDER: begin
                n_res.bin_found     = 6'(r_bin);
                n_res.interp_value  = '0;
                n_res.result_status = nti_pkg::STAT_ORDER;
                // even window: one more point above the bin
                n_org = k[0] ? org_b : org_b + IW'(1);
            end
            nti_pkg::S_NB_LO: begin
                n_e1 = sub_d;
            end
            nti_pkg::S_NB_HI: begin
                // nearer neighbour above: shift the odd window up
                if (r_e1 > sub_d) begin
                    n_org = r_org + IW'(1);
                end
            end
            nti_pkg::S_CLAMP: begin
                if (r_org < 0) begin
                    n_org = '0;
                end else if (r_org > r_n - IW'(k)) begin
                    n_org = r_n - IW'(k);
                end
                n_i = '0;
            end
            nti_pkg::S_FILL_WR: begin
                n_s[SW'(r_i)] = r_oq;
                n_i = r_i + KW'(1);
                if (r_i + KW'(1) == k) begin
                    n_i = '0;
                    n_c = k;
                    n_m = KW'(1);
                end
            end
            nti_pkg::S_NV_RDM: begin
                n_di = r_dq;
            end
            nti_pkg::S_NV_A: begin
                n_dm  = r_dq;
                n_a   = sub_sat;
                n_sat = r_sat | sub_ovf;
            end
            nti_pkg::S_NV_B: begin
                n_b   = sub_sat;
                n_sat = r_sat | sub_ovf;
            end
            nti_pkg::S_NV_D: begin
                n_den = sub_sat;
                n_sat = r_sat | sub_ovf;
                if (sub_sat == 32'sd0) begin
                    n_res.interp_value  = '0;
                    n_res.result_status = nti_pkg::STAT_ZERODIV;
                end
            end
            nti_pkg::S_NV_M1: n_pa = mul_p;
            nti_pkg::S_NV_M2: n_pb = mul_p;
            nti_pkg::S_NV_SUM: n_num = r_pa + r_pb;
            nti_pkg::S_NV_DIV: begin
                // queue step: drop the front, new value at the live tail
                if (div_res.done) begin
                    for (int j = 0; j < SL - 1; j++) begin
                        n_s[j] = r_s[j + 1];
                    end
                    n_s[SW'(r_c - KW'(1))] = q_sat;
                    n_sat = r_sat | q_ovf;
                    n_i   = r_i + KW'(1);
                end
            end
            nti_pkg::S_NV_DROP: begin
                for (int j = 0; j < SL - 1; j++) begin
                    n_s[j] = r_s[j + 1];
                end
                n_c = r_c - KW'(1);
                n_m = r_m + KW'(1);
                n_i = '0;
            end
            nti_pkg::S_FINISH: begin
                n_res.interp_value  = r_s[0];
                n_res.result_status = r_sat ? nti_pkg::STAT_SAT : nti_pkg::STAT_OK;
            end
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nti_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_n <= n_n; r_lo <= n_lo; r_hi <= n_hi; r_mid <= n_mid;
        r_bin <= n_bin; r_org <= n_org; r_i <= n_i; r_c <= n_c; r_m <= n_m;
        r_e1 <= n_e1; r_di <= n_di; r_dm <= n_dm; r_a <= n_a; r_b <= n_b;
        r_den <= n_den; r_pa <= n_pa; r_pb <= n_pb; r_num <= n_num;
        r_sat <= n_sat; r_res <= n_res; r_s <= n_s;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == nti_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nti_pkg::S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> r_state == nti_pkg::S_NV_DIV)
        else $error("divider finished outside its wait state");

    a_neville_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == nti_pkg::S_NV_RDI |-> (r_c > KW'(1)) && (r_i + KW'(1) < r_c))
        else $error("Neville step outside the live window");

    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.opcode == nti_pkg::OP_QUERY |=> r_state == nti_pkg::S_RD_FIRST)
        else $error("query transfer did not start the sequence");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == nti_pkg::S_DONE)
        else $error("result shown without a finished item");
`endif

endmodule
